// ----- rtl/set_assoc_lru_writeback_cache_tags_assert.svh -----
// Assertion macros shared by the cache tag controller.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef SET_ASSOC_LRU_WRITEBACK_CACHE_TAGS_ASSERT_SVH
`define SET_ASSOC_LRU_WRITEBACK_CACHE_TAGS_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define SALC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define SALC_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- rtl/salc_pkg.sv -----
package salc_pkg;

    // Default geometry.
    localparam int SETS_DEF = 256;
    localparam int WAYS_DEF = 8;

    // Fixed field widths.
    localparam int ADDR_W     = 32;
    localparam int TAG_W      = ADDR_W;
    localparam int FUNC_W     = 1;
    localparam int WAY_OUT_W  = 3;
    localparam int OFFSET_W   = 3;
    localparam int INDEX_W    = 4;
    localparam int WAYCFG_W   = 4;
    // Holds a way count up to 16 and a shift of offset plus index bits.
    localparam int WAYCNT_W   = 5;
    localparam int SHIFT_W    = 5;

    // Result transaction layout.
    localparam int OUT_FIELDS_W = 1 + 1 + ADDR_W + 1 + ADDR_W + WAY_OUT_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int IN_DATA_W    = ((ADDR_W + 7) / 8) * 8;

    // Configuration port.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_INDEX_BITS  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd2;

    localparam logic [OFFSET_W-1:0] OFFSET_BITS_RST = 3'd5;
    localparam logic [INDEX_W-1:0]  INDEX_BITS_RST  = 4'd8;
    localparam logic [WAYCFG_W-1:0] WAYS_IN_USE_RST = 4'd8;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

endpackage

// ----- rtl/set_assoc_lru_writeback_cache_tags.sv -----
// Flow: an accepted access reads its set row in the accept cycle, is compared in the compute
// cycle and its result is registered before it is presented. No new access is taken during
// the compute cycle, and the updated set row is written back in that compute cycle.
// Reset: asynchronous, active low; afterwards a clearing pass over all sets initializes
// every set row (invalid, clean, LRU rank equal to the way number) before accesses are taken.
module set_assoc_lru_writeback_cache_tags
    import salc_pkg::*;
#(
    parameter int SETS = SETS_DEF,
    parameter int WAYS = WAYS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    // Access channel.
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [IN_DATA_W-1:0]    s_tdata,   // [31:0] address
    input  logic [FUNC_W-1:0]       s_tuser,   // [0] func (0 read, 1 write)
    // Result channel.
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // [0] hit, [1] fill_valid, [33:2] fill_address, [34] writeback_valid,
    // [66:35] writeback_address, [69:67] way_used, [71:70] zero
    output logic [OUT_DATA_W-1:0]   m_tdata,
    // Configuration port.
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready
);

    // Geometry derived from the parameters. MAX_IB is the largest b with 2^b <= SETS.
    localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int MAX_IB  = $clog2(SETS + 1) - 1;
    localparam int RANK_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ENTRY_W = TAG_W + 2 + RANK_W;
    localparam int ROW_W   = WAYS * ENTRY_W;
    localparam int PAD_W   = OUT_DATA_W - OUT_FIELDS_W;

    // ------------------------------------------------------------------
    // Configuration registers. Writes complete in the APB access phase;
    // pready is tied high, so there are no wait states.
    // ------------------------------------------------------------------
    logic [OFFSET_W-1:0] offset_bits_reg;
    logic [INDEX_W-1:0]  index_bits_reg;
    logic [WAYCFG_W-1:0] ways_in_use_reg;
    logic                cfg_write;
    logic [REG_IDX_W-1:0] cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= OFFSET_BITS_RST;
            index_bits_reg  <= INDEX_BITS_RST;
            ways_in_use_reg <= WAYS_IN_USE_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_OFFSET_BITS: offset_bits_reg <= pwdata[OFFSET_W-1:0];
                REG_INDEX_BITS:  index_bits_reg  <= pwdata[INDEX_W-1:0];
                REG_WAYS_IN_USE: ways_in_use_reg <= pwdata[WAYCFG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_OFFSET_BITS: prdata = APB_DATA_W'(offset_bits_reg);
            REG_INDEX_BITS:  prdata = APB_DATA_W'(index_bits_reg);
            REG_WAYS_IN_USE: prdata = APB_DATA_W'(ways_in_use_reg);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Effective configuration. The index width saturates so that the set
    // index always lands on a real set, and the way count is clamped to
    // the range one to WAYS.
    // ------------------------------------------------------------------
    logic [INDEX_W-1:0]  ib_eff;
    logic [SHIFT_W-1:0]  tag_shift;
    logic [WAYCNT_W-1:0] nways;

    assign ib_eff    = (index_bits_reg > INDEX_W'(MAX_IB)) ? INDEX_W'(MAX_IB) : index_bits_reg;
    assign tag_shift = SHIFT_W'(offset_bits_reg) + SHIFT_W'(ib_eff);

    always_comb
    begin
        if (ways_in_use_reg == '0)
        begin
            nways = WAYCNT_W'(1);
        end
        else if (WAYCNT_W'(ways_in_use_reg) > WAYCNT_W'(WAYS))
        begin
            nways = WAYCNT_W'(WAYS);
        end
        else
        begin
            nways = WAYCNT_W'(ways_in_use_reg);
        end
    end

    // ------------------------------------------------------------------
    // Handshake and control. An access is accepted only when no other access
    // is in flight, the clearing pass is over and the output register is
    // empty or being emptied in the same cycle.
    // ------------------------------------------------------------------
    logic              clearing_reg, clearing_next;
    logic [SET_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic              busy_reg;
    logic              m_tvalid_reg, m_tvalid_next;
    logic              in_acc;

    assign s_tready = !clearing_reg && !busy_reg && (!m_tvalid_reg || m_tready);
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clearing_reg)
        begin
            if (clr_cnt_reg == SET_W'(SETS - 1))
            begin
                clearing_next = 1'b0;
            end
            else
            begin
                clr_cnt_next = clr_cnt_reg + SET_W'(1);
            end
        end
    end

    // The compute cycle always produces a result, so the output register
    // fills right after busy and drains when the sink takes it.
    always_comb
    begin
        if (busy_reg)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_cnt_reg  <= clr_cnt_next;
            busy_reg     <= in_acc;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // ------------------------------------------------------------------
    // Address split in the accept cycle. The set index addresses the set
    // memory directly; tag, set and fill address are held for the compute cycle.
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] in_addr;
    logic [ADDR_W-1:0] set_full;
    logic [SET_W-1:0]  in_set;
    logic [TAG_W-1:0]  in_tag;
    logic [ADDR_W-1:0] in_fill;

    logic              func_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [SET_W-1:0]  set_reg;
    logic [ADDR_W-1:0] fill_addr_reg;

    assign in_addr  = s_tdata[ADDR_W-1:0];
    assign set_full = (in_addr >> offset_bits_reg) & ~({ADDR_W{1'b1}} << ib_eff);
    assign in_set   = set_full[SET_W-1:0];
    assign in_tag   = TAG_W'(in_addr >> tag_shift);
    assign in_fill  = in_addr & ({ADDR_W{1'b1}} << offset_bits_reg);

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            func_reg      <= s_tuser[0];
            tag_reg       <= in_tag;
            set_reg       <= in_set;
            fill_addr_reg <= in_fill;
        end
    end

    // ------------------------------------------------------------------
    // Set memory: one row per set, each way holding {tag, valid, dirty, rank}.
    // It is read in the accept cycle and written in the compute cycle, so a
    // following access to the same set always reads the updated row.
    // ------------------------------------------------------------------
    logic             ram_we;
    logic [SET_W-1:0] ram_waddr;
    logic [ROW_W-1:0] ram_wdata;
    logic [ROW_W-1:0] ram_rdata;
    logic [ROW_W-1:0] init_row;
    logic [ROW_W-1:0] new_row;

    salc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_set_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (in_set),
        .rdata (ram_rdata)
    );

    assign ram_we    = clearing_reg || busy_reg;
    assign ram_waddr = clearing_reg ? clr_cnt_reg : set_reg;
    assign ram_wdata = clearing_reg ? init_row : new_row;

    // After reset every way is invalid and clean, and its rank is its own number.
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            init_row[w*ENTRY_W +: ENTRY_W] = {{TAG_W{1'b0}}, 1'b0, 1'b0, RANK_W'(w)};
        end
    end

    // ------------------------------------------------------------------
    // Compute cycle: tag compare, victim choice and LRU update on the row.
    // ------------------------------------------------------------------
    logic [TAG_W-1:0]  way_tag   [WAYS];
    logic              way_valid [WAYS];
    logic              way_dirty [WAYS];
    logic [RANK_W-1:0] way_rank  [WAYS];
    logic              way_en    [WAYS];

    logic              found;
    logic [RANK_W-1:0] hit_way;
    logic              empty;
    logic [RANK_W-1:0] empty_way;
    logic [RANK_W-1:0] vic_way;
    logic [RANK_W-1:0] best_rank;
    logic [RANK_W-1:0] sel_way;
    logic [RANK_W-1:0] sel_rank;

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            way_rank[w]  = ram_rdata[w*ENTRY_W +: RANK_W];
            way_dirty[w] = ram_rdata[w*ENTRY_W + RANK_W];
            way_valid[w] = ram_rdata[w*ENTRY_W + RANK_W + 1];
            way_tag[w]   = ram_rdata[w*ENTRY_W + RANK_W + 2 +: TAG_W];
            way_en[w]    = WAYCNT_W'(w) < nways;
        end
    end

    // The first valid way with a matching tag is the hit.
    always_comb
    begin
        found   = 1'b0;
        hit_way = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!found && way_en[w] && way_valid[w] && (way_tag[w] == tag_reg))
            begin
                found   = 1'b1;
                hit_way = RANK_W'(w);
            end
        end
    end

    // The first invalid way in use takes a missing block.
    always_comb
    begin
        empty     = 1'b0;
        empty_way = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!empty && way_en[w] && !way_valid[w])
            begin
                empty     = 1'b1;
                empty_way = RANK_W'(w);
            end
        end
    end

    // In a full set the victim is the way with the highest rank; a strict
    // compare keeps the lowest way among equal ranks.
    always_comb
    begin
        best_rank = way_rank[0];
        vic_way   = '0;
        for (int w = 1; w < WAYS; w++)
        begin
            if (way_en[w] && (way_rank[w] > best_rank))
            begin
                best_rank = way_rank[w];
                vic_way   = RANK_W'(w);
            end
        end
    end

    always_comb
    begin
        if (found)
        begin
            sel_way = hit_way;
        end
        else if (empty)
        begin
            sel_way = empty_way;
        end
        else
        begin
            sel_way = vic_way;
        end
    end

    assign sel_rank = way_rank[sel_way];

    // Row update. Ways in use that ranked below the accessed way age by one,
    // and the accessed way becomes the most recent. A hit only adds the dirty
    // mark on a write; a fill installs the tag, valid, dirty on a write.
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            if (RANK_W'(w) == sel_way)
            begin
                if (found)
                begin
                    new_row[w*ENTRY_W +: ENTRY_W] = {way_tag[w], way_valid[w],
                                                     way_dirty[w] || (func_reg == FUNC_WRITE),
                                                     {RANK_W{1'b0}}};
                end
                else
                begin
                    new_row[w*ENTRY_W +: ENTRY_W] = {tag_reg, 1'b1,
                                                     (func_reg == FUNC_WRITE),
                                                     {RANK_W{1'b0}}};
                end
            end
            else if (way_en[w] && (way_rank[w] < sel_rank))
            begin
                new_row[w*ENTRY_W +: ENTRY_W] = {way_tag[w], way_valid[w], way_dirty[w],
                                                 way_rank[w] + RANK_W'(1)};
            end
            else
            begin
                new_row[w*ENTRY_W +: ENTRY_W] = {way_tag[w], way_valid[w], way_dirty[w],
                                                 way_rank[w]};
            end
        end
    end

    // ------------------------------------------------------------------
    // Result fields. A dirty victim is rebuilt from its tag and the set index.
    // ------------------------------------------------------------------
    logic                 hit_next, hit_reg;
    logic                 fill_valid_next, fill_valid_reg;
    logic [ADDR_W-1:0]    fill_address_next, fill_address_reg;
    logic                 wb_valid_next, wb_valid_reg;
    logic [ADDR_W-1:0]    wb_address_next, wb_address_reg;
    logic [WAY_OUT_W-1:0] way_used_next, way_used_reg;

    assign hit_next          = found;
    assign fill_valid_next   = !found;
    assign fill_address_next = found ? '0 : fill_addr_reg;
    assign wb_valid_next     = !found && !empty && way_dirty[vic_way];
    assign wb_address_next   = wb_valid_next ?
                               ((ADDR_W'(way_tag[vic_way]) << tag_shift) |
                                (ADDR_W'(set_reg) << offset_bits_reg)) : '0;
    assign way_used_next     = WAY_OUT_W'(sel_way);

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            hit_reg          <= hit_next;
            fill_valid_reg   <= fill_valid_next;
            fill_address_reg <= fill_address_next;
            wb_valid_reg     <= wb_valid_next;
            wb_address_reg   <= wb_address_next;
            way_used_reg     <= way_used_next;
        end
    end

    assign m_tdata = {{PAD_W{1'b0}}, way_used_reg, wb_address_reg, wb_valid_reg,
                      fill_address_reg, fill_valid_reg, hit_reg};

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
`include "set_assoc_lru_writeback_cache_tags_assert.svh"

    `SALC_ASSERT_NEXT(a_accept_busy, in_acc, busy_reg && !s_tready, "accepted access did not enter the compute cycle")
    `SALC_ASSERT_NEXT(a_busy_result, busy_reg, m_tvalid_reg, "compute cycle did not produce a result")
    `SALC_ASSERT_SAME(a_hit_xor_fill, m_tvalid_reg, hit_reg != fill_valid_reg, "result is both or neither hit and fill")
    `SALC_ASSERT_SAME(a_wb_on_miss, m_tvalid_reg && wb_valid_reg, fill_valid_reg, "writeback reported without a miss")

endmodule

// ----- rtl/salc_ram.sv -----
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- tb/cache_tag_checker.sv -----
module cache_tag_checker
    import salc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [FUNC_W-1:0]     s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  pready,
    output int                    fail_count,
    output int                    pending
);

    localparam int MAX_IDX = $clog2(SETS_DEF + 1) - 1;
    localparam int ENTRIES = SETS_DEF * WAYS_DEF;

    // Mirrors the result transaction layout, lowest field last.
    typedef struct packed {
        logic [WAY_OUT_W-1:0] way_used;
        logic [ADDR_W-1:0]    wb_address;
        logic                 wb_valid;
        logic [ADDR_W-1:0]    fill_address;
        logic                 fill_valid;
        logic                 hit;
    } tag_resp_t;

    logic [OFFSET_W-1:0] offset_bits;
    logic [INDEX_W-1:0]  index_bits;
    logic [WAYCFG_W-1:0] ways_in_use;

    logic [TAG_W-1:0] tag_mem   [ENTRIES];
    bit               valid_mem [ENTRIES];
    bit               dirty_mem [ENTRIES];
    int unsigned      rank_mem  [ENTRIES];

    tag_resp_t expected_resp_q[$];

    // Looks up one access, updates the tag state and returns the result it causes.
    task automatic cache_lookup(input logic is_write, input logic [ADDR_W-1:0] addr,
                                output tag_resp_t r);
        int          ib;
        int          nways;
        int          set;
        int          base;
        int          way;
        int unsigned top_rank;
        int unsigned ref_rank;
        logic [TAG_W-1:0] tag;
        bit          found;
        bit          empty;
        ib    = (index_bits > MAX_IDX) ? MAX_IDX : int'(index_bits);
        nways = (ways_in_use == 0) ? 1 :
                (ways_in_use > WAYS_DEF) ? WAYS_DEF : int'(ways_in_use);
        set   = int'((addr >> offset_bits) & ((1 << ib) - 1));
        tag   = addr >> (offset_bits + ib);
        base  = set * WAYS_DEF;
        r     = '0;
        found = 1'b0;
        empty = 1'b0;
        way   = 0;
        for (int w = 0; w < nways; w++)
        begin
            if (!found && valid_mem[base + w] && tag_mem[base + w] == tag)
            begin
                way   = w;
                found = 1'b1;
            end
        end
        if (found)
        begin
            if (is_write == FUNC_WRITE)
                dirty_mem[base + way] = 1'b1;
        end
        else
        begin
            for (int w = 0; w < nways; w++)
            begin
                if (!empty && !valid_mem[base + w])
                begin
                    way   = w;
                    empty = 1'b1;
                end
            end
            if (!empty)
            begin
                // The lowest way wins a tie on the highest rank.
                way      = 0;
                top_rank = rank_mem[base];
                for (int w = 1; w < nways; w++)
                begin
                    if (rank_mem[base + w] > top_rank)
                    begin
                        top_rank = rank_mem[base + w];
                        way      = w;
                    end
                end
                if (dirty_mem[base + way])
                begin
                    r.wb_valid   = 1'b1;
                    r.wb_address = (tag_mem[base + way] << (offset_bits + ib)) |
                                   (ADDR_W'(set) << offset_bits);
                end
            end
            tag_mem[base + way]   = tag;
            valid_mem[base + way] = 1'b1;
            dirty_mem[base + way] = (is_write == FUNC_WRITE);
            r.fill_valid          = 1'b1;
            r.fill_address        = (addr >> offset_bits) << offset_bits;
        end
        ref_rank = rank_mem[base + way];
        for (int w = 0; w < nways; w++)
        begin
            if (rank_mem[base + w] < ref_rank)
                rank_mem[base + w]++;
        end
        rank_mem[base + way] = 0;
        r.hit      = found;
        r.way_used = WAY_OUT_W'(way);
    endtask

    task automatic check_field(input string name, input logic [ADDR_W-1:0] exp_v,
                               input logic [ADDR_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tag_resp_t got;
        tag_resp_t want;
        if (!rst_n)
        begin
            offset_bits = OFFSET_BITS_RST;
            index_bits  = INDEX_BITS_RST;
            ways_in_use = WAYS_IN_USE_RST;
            for (int i = 0; i < ENTRIES; i++)
            begin
                tag_mem[i]   = '0;
                valid_mem[i] = 1'b0;
                dirty_mem[i] = 1'b0;
                rank_mem[i]  = i % WAYS_DEF;
            end
            expected_resp_q.delete();
            fail_count = 0;
            pending   <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_OFFSET_BITS: offset_bits = pwdata[OFFSET_W-1:0];
                    REG_INDEX_BITS:  index_bits  = pwdata[INDEX_W-1:0];
                    REG_WAYS_IN_USE: ways_in_use = pwdata[WAYCFG_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got = tag_resp_t'(m_tdata[$bits(tag_resp_t)-1:0]);
                if (expected_resp_q.size() == 0)
                begin
                    $error("result transaction with no access waiting for it");
                    fail_count++;
                end
                else
                begin
                    want = expected_resp_q.pop_front();
                    check_field("hit", want.hit, got.hit);
                    check_field("fill_valid", want.fill_valid, got.fill_valid);
                    check_field("fill_address", want.fill_address, got.fill_address);
                    check_field("writeback_valid", want.wb_valid, got.wb_valid);
                    check_field("writeback_address", want.wb_address, got.wb_address);
                    check_field("way_used", want.way_used, got.way_used);
                end
            end
            if (s_tvalid && s_tready)
            begin
                cache_lookup(s_tuser[0], s_tdata[ADDR_W-1:0], want);
                expected_resp_q.push_back(want);
            end
            pending <= expected_resp_q.size();
        end
    end

endmodule

// ----- tb/tb_set_assoc_lru_writeback_cache_tags.sv -----
module tb_set_assoc_lru_writeback_cache_tags;
    import salc_pkg::*;

    // Largest set index width the default geometry can address.
    localparam int MAX_IDX = $clog2(SETS_DEF + 1) - 1;
    // Generous bound on the whole run, including the clearing pass after reset.
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES = 8;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;   // [31:0] address
    logic [FUNC_W-1:0]     s_tuser  = '0;   // [0] func
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [0] hit, [1] fill_valid, [33:2] fill_address, [34] writeback_valid,
    // [66:35] writeback_address, [69:67] way_used
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending;

    // Configuration settings walked through after the reset phase. The list covers
    // a direct-mapped single set, the widest offset, an index width that must
    // saturate, a way count of zero and way counts above the physical ways.
    int phase_offset [PHASES] = '{0, 7, 4, 2, 3, 1, 5, 6};
    int phase_index  [PHASES] = '{0, 8, 15, 3, 2, 9, 4, 1};
    int phase_ways   [PHASES] = '{1, 8, 15, 0, 4, 3, 12, 2};
    int phase_items  [PHASES] = '{60, 100, 80, 60, 120, 100, 100, 70};

    // The stimulus side keeps its own copy of the configuration so that it can
    // aim addresses at a few sets and tags that will actually collide.
    int cur_offset = OFFSET_BITS_RST;
    int cur_index  = INDEX_BITS_RST;
    int cur_ways   = WAYS_IN_USE_RST;

    // Number of transactions left in the current sender burst.
    int burst_left = 0;
    int cycle_count = 0;

    set_assoc_lru_writeback_cache_tags dut (.*);

    cache_tag_checker checker_i (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: a run that hangs is a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result receiver. It switches at random between its own stall patterns, and once, well
    // into the run, it stops taking results for a long stretch so that the block backs up and
    // has to stall the access channel.
    int unsigned results_seen = 0;
    int unsigned hold_left    = 0;
    int unsigned mode_left    = 0;
    int          stall_mode   = 0;
    bit          hold_done    = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                results_seen++;
            if (!hold_done && results_seen == 420)
            begin
                hold_done = 1'b1;
                hold_left = 180;
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 80);
            end
            else
            begin
                mode_left--;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (stall_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= $urandom_range(0, 1);
                    2:       m_tready <= ($urandom_range(0, 7) != 0);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Offers one access and returns at the edge where it is accepted. Accesses go
    // out in bursts; a new burst may start after a gap or right away.
    task automatic send_access(input logic [FUNC_W-1:0] func, input logic [ADDR_W-1:0] addr);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= addr;
        s_tuser  <= func;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left--;
    endtask

    // Lets every outstanding result come back, then idles before returning.
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    // One register write with a setup phase and an access phase, after which the bus goes idle.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Builds a byte address from a tag, a set and an offset under the current
    // configuration. Bits of the tag that fall off the top are simply lost.
    function automatic logic [ADDR_W-1:0] block_addr(input logic [ADDR_W-1:0] tag,
                                                     input logic [ADDR_W-1:0] set,
                                                     input logic [ADDR_W-1:0] off);
        int ib;
        ib = (cur_index > MAX_IDX) ? MAX_IDX : cur_index;
        return (tag << (cur_offset + ib)) |
               ((set & ((1 << ib) - 1)) << cur_offset) |
               (off & ((1 << cur_offset) - 1));
    endfunction

    // Random traffic. Most accesses go to a few sets with a tag pool a little
    // larger than the ways in use, so hits, fills, evictions and dirty writebacks
    // all occur often; the rest are fully random addresses.
    task automatic random_phase(input int n);
        logic [ADDR_W-1:0] tag_pool [12];
        logic [ADDR_W-1:0] set_pool [3];
        logic [ADDR_W-1:0] addr;
        int ntags;
        int nsets;
        int nways;
        nways = (cur_ways == 0) ? 1 : (cur_ways > WAYS_DEF) ? WAYS_DEF : cur_ways;
        ntags = nways + $urandom_range(1, 4);
        nsets = $urandom_range(1, 3);
        foreach (tag_pool[i])
            tag_pool[i] = $urandom;
        foreach (set_pool[i])
            set_pool[i] = $urandom;
        repeat (n)
        begin
            if ($urandom_range(0, 9) == 0)
                addr = $urandom;
            else
                addr = block_addr(tag_pool[$urandom_range(0, ntags - 1)],
                                  set_pool[$urandom_range(0, nsets - 1)], $urandom);
            send_access($urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ, addr);
        end
    endtask

    initial
    begin
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed accesses under the reset configuration: the lowest and highest
        // addresses, a read hit and a write hit, then one set filled to all eight
        // ways. Further misses to that set evict by LRU rank, first a dirty
        // victim that must be written back, then a clean one that must not.
        send_access(FUNC_READ, 32'h0000_0000);
        send_access(FUNC_WRITE, 32'hFFFF_FFFF);
        send_access(FUNC_READ, 32'hFFFF_FFE0);
        send_access(FUNC_WRITE, 32'h0000_001F);
        for (int t = 1; t <= 8; t++)
            send_access((t % 2 == 1) ? FUNC_WRITE : FUNC_READ, block_addr(t, 3, t));
        send_access(FUNC_READ, block_addr(9, 3, 0));
        send_access(FUNC_WRITE, block_addr(10, 3, 0));
        send_access(FUNC_READ, block_addr(1, 3, 0));
        send_access(FUNC_WRITE, block_addr(9, 3, 31));

        random_phase(60);

        // Each later phase reconfigures the idle block. Stored tags survive and
        // are read under the new split of the address.
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            write_reg(REG_OFFSET_BITS, phase_offset[p]);
            write_reg(REG_INDEX_BITS, phase_index[p]);
            write_reg(REG_WAYS_IN_USE, phase_ways[p]);
            cur_offset = phase_offset[p];
            cur_index  = phase_index[p];
            cur_ways   = phase_ways[p];
            random_phase(phase_items[p]);
        end

        drain();
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
